// ===== rtl/core/wse_pkg.sv =====
// ----------------------------------------------------------------------------
// wse_pkg
// Types and constants shared by the two-stage wash sequencer modules.
// ----------------------------------------------------------------------------
package wse_pkg;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_ARM         = 4'd1,
    PH_FILL1       = 4'd2,
    PH_SOAK1       = 4'd3,
    PH_DELAY1      = 4'd4,
    PH_HANDOFF1    = 4'd5,
    PH_DRAIN1      = 4'd7,
    PH_REFILL_WAIT = 4'd8,
    PH_FILL2       = 4'd9,
    PH_SOAK2       = 4'd10,
    PH_DELAY2      = 4'd11,
    PH_HANDOFF2    = 4'd12,
    PH_DRAIN2      = 4'd13,
    PH_POST        = 4'd14,
    PH_FINISH      = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    CFG_PUMP_ON_LEVEL  = 3'd0,
    CFG_FIRST_TARGET   = 3'd1,
    CFG_SECOND_TARGET  = 3'd2,
    CFG_SOAK_TIME      = 3'd3,
    CFG_STEP_DELAY     = 3'd4,
    CFG_LOW_FILL_TO    = 3'd5,
    CFG_TOTAL_FILL_TO  = 3'd6,
    CFG_DRAIN_WAIT_TO  = 3'd7
  } cfg_index_t;

  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned DUR_W   = 20;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 20;

  localparam logic [1:0] DRAIN_NONE  = 2'd0;
  localparam logic [1:0] DRAIN_SET   = 2'd1;
  localparam logic [1:0] DRAIN_CLEAR = 2'd2;

  localparam logic [2:0] ABORT_NONE      = 3'd0;
  localparam logic [2:0] ABORT_LOW1      = 3'd1;
  localparam logic [2:0] ABORT_TOTAL1    = 3'd2;
  localparam logic [2:0] ABORT_DRAIN1    = 3'd3;
  localparam logic [2:0] ABORT_LOW2      = 3'd4;
  localparam logic [2:0] ABORT_TOTAL2    = 3'd5;
  localparam logic [2:0] ABORT_DRAIN2    = 3'd6;

  localparam int unsigned ACT_INLET  = 0;
  localparam int unsigned ACT_PUMP   = 1;
  localparam int unsigned ACT_CIRC   = 2;
  localparam int unsigned ACT_OUTLET = 3;

  typedef struct packed {
    logic [LEVEL_W-1:0] pump_on_level;
    logic [LEVEL_W-1:0] first_fill_target;
    logic [LEVEL_W-1:0] second_fill_target;
    logic [DUR_W-1:0]   soak_time_ms;
    logic [DUR_W-1:0]   step_delay_ms;
    logic [DUR_W-1:0]   low_fill_timeout_ms;
    logic [DUR_W-1:0]   total_fill_timeout_ms;
    logic [DUR_W-1:0]   drain_wait_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic               start_request;
    logic [LEVEL_W-1:0] level;
    logic               drain_busy;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic       inlet_valve;
    logic       circ_pump;
    logic       circ_valve;
    logic       outlet_valve;
    logic       sample_enable;
    logic       pump_permit;
    logic [1:0] drain_command;
    logic       clear_start;
    logic [2:0] abort_code;
    logic [3:0] phase;
  } out_item_t;

endpackage

// ===== rtl/core/wse_in_if.sv =====
// ----------------------------------------------------------------------------
// wse_in_if
// Valid/ready channel that carries one task tick word.
// ----------------------------------------------------------------------------
interface wse_in_if;
  logic              valid;
  logic              ready;
  wse_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wse_out_if.sv =====
// ----------------------------------------------------------------------------
// wse_out_if
// Valid/ready channel that carries one sequencer result word.
// ----------------------------------------------------------------------------
interface wse_out_if;
  logic               valid;
  logic               ready;
  wse_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/two_stage_wash_sequencer.sv =====
// ----------------------------------------------------------------------------
// two_stage_wash_sequencer
// Fifteen-phase two-stage wash sequencer: one task tick in, one actuator and
// status word out.
//
//   Channel  Direction  Handshake          Word
//   in_ch    sink       valid/ready        start, level, drain busy, now_ms
//   out_ch   source     valid/ready        actuators, drain cmd, abort, phase
//   cfg_*    sink       write enable only  register index, 20-bit data
//
// A new tick is taken every cycle while the result word is not stalled.
// The result word of an accepted tick is held in the result register and
// shows on out_ch in the cycle after the tick is accepted.
// A stalled result holds the input off only until it is taken; the input
// is accepted in the same cycle that the held word leaves.
// Reset is synchronous and puts the sequencer in idle with default registers.
// ----------------------------------------------------------------------------
module two_stage_wash_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  wse_in_if.sink                    in_ch,
  wse_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [wse_pkg::CFG_W-1:0] cfg_wdata
);

  wse_pkg::cfg_t      cfg;
  wse_pkg::out_item_t result;
  logic               free;
  logic               accept;

  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  wse_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wse_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_ch.payload),
    .cfg    (cfg),
    .result (result)
  );

  wse_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (result),
    .take      (out_ch.ready),
    .free      (free),
    .valid     (out_ch.valid),
    .data      (out_ch.payload)
  );

endmodule

// ===== rtl/core/wse_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wse_cfg_regs
// Configuration register file with reset defaults and a plain write port.
// ----------------------------------------------------------------------------
module wse_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [wse_pkg::CFG_W-1:0]  cfg_wdata,
  output wse_pkg::cfg_t              cfg
);

  wse_pkg::cfg_t cfg_r;
  wse_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (wse_pkg::cfg_index_t'(cfg_index))
        wse_pkg::CFG_PUMP_ON_LEVEL: begin
          cfg_nxt.pump_on_level = cfg_wdata[wse_pkg::LEVEL_W-1:0];
        end
        wse_pkg::CFG_FIRST_TARGET: begin
          cfg_nxt.first_fill_target = cfg_wdata[wse_pkg::LEVEL_W-1:0];
        end
        wse_pkg::CFG_SECOND_TARGET: begin
          cfg_nxt.second_fill_target = cfg_wdata[wse_pkg::LEVEL_W-1:0];
        end
        wse_pkg::CFG_SOAK_TIME: begin
          cfg_nxt.soak_time_ms = cfg_wdata[wse_pkg::DUR_W-1:0];
        end
        wse_pkg::CFG_STEP_DELAY: begin
          cfg_nxt.step_delay_ms = cfg_wdata[wse_pkg::DUR_W-1:0];
        end
        wse_pkg::CFG_LOW_FILL_TO: begin
          cfg_nxt.low_fill_timeout_ms = cfg_wdata[wse_pkg::DUR_W-1:0];
        end
        wse_pkg::CFG_TOTAL_FILL_TO: begin
          cfg_nxt.total_fill_timeout_ms = cfg_wdata[wse_pkg::DUR_W-1:0];
        end
        wse_pkg::CFG_DRAIN_WAIT_TO: begin
          cfg_nxt.drain_wait_timeout_ms = cfg_wdata[wse_pkg::DUR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pump_on_level         <= 12'd1000;
      cfg_r.first_fill_target     <= 12'd2000;
      cfg_r.second_fill_target    <= 12'd3000;
      cfg_r.soak_time_ms          <= 20'd60000;
      cfg_r.step_delay_ms         <= 20'd12000;
      cfg_r.low_fill_timeout_ms   <= 20'd30000;
      cfg_r.total_fill_timeout_ms <= 20'd120000;
      cfg_r.drain_wait_timeout_ms <= 20'd90000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/wse_seq_core.sv =====
// ----------------------------------------------------------------------------
// wse_seq_core
// Sequencer state and the per-tick transition logic; the state advances on
// every accepted word and the result word is formed in the same cycle.
// ----------------------------------------------------------------------------
module wse_seq_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  wse_pkg::in_item_t  item,
  input  wse_pkg::cfg_t      cfg,
  output wse_pkg::out_item_t result
);

  wse_pkg::phase_t                phase_r;
  wse_pkg::phase_t                phase_nxt;
  logic [wse_pkg::TIME_W-1:0]     start_ms_r;
  logic [wse_pkg::TIME_W-1:0]     start_ms_nxt;
  logic                           permit_r;
  logic                           permit_nxt;
  logic [3:0]                     act_r;
  logic [3:0]                     act_nxt;
  logic                           sample_r;
  logic                           sample_nxt;
  logic [1:0]                     drain_cmd;
  logic                           clr;
  logic [2:0]                     code;

  logic [wse_pkg::TIME_W-1:0]     elapsed;
  logic                           soak_done;
  logic                           step_done;
  logic                           low_done;
  logic                           total_done;
  logic                           drain_done;
  logic                           lvl_hi;
  logic                           low_to;
  logic                           fill_abort;
  logic                           fill_done;
  logic                           is_fill2;
  logic [wse_pkg::LEVEL_W-1:0]    target;
  logic                           fill_permit;

  assign elapsed    = item.now_ms - start_ms_r;
  assign soak_done  = elapsed >= {12'd0, cfg.soak_time_ms};
  assign step_done  = elapsed >= {12'd0, cfg.step_delay_ms};
  assign low_done   = elapsed >= {12'd0, cfg.low_fill_timeout_ms};
  assign total_done = elapsed >= {12'd0, cfg.total_fill_timeout_ms};
  assign drain_done = elapsed >= {12'd0, cfg.drain_wait_timeout_ms};

  assign is_fill2    = (phase_r == wse_pkg::PH_FILL2);
  assign target      = is_fill2 ? cfg.second_fill_target : cfg.first_fill_target;
  assign lvl_hi      = item.level > cfg.pump_on_level;
  assign low_to      = !lvl_hi && low_done;
  assign fill_abort  = low_to || total_done;
  assign fill_done   = item.level >= target;
  assign fill_permit = permit_r | lvl_hi;

  always_comb begin
    phase_nxt = phase_r;
    if (!item.start_request) begin
      phase_nxt = wse_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        wse_pkg::PH_IDLE: begin
          phase_nxt = wse_pkg::PH_ARM;
        end
        wse_pkg::PH_ARM: begin
          phase_nxt = wse_pkg::PH_FILL1;
        end
        wse_pkg::PH_FILL1: begin
          if (fill_abort) begin
            phase_nxt = wse_pkg::PH_IDLE;
          end else if (fill_done) begin
            phase_nxt = wse_pkg::PH_SOAK1;
          end
        end
        wse_pkg::PH_FILL2: begin
          if (fill_abort) begin
            phase_nxt = wse_pkg::PH_IDLE;
          end else if (fill_done) begin
            phase_nxt = wse_pkg::PH_SOAK2;
          end
        end
        wse_pkg::PH_SOAK1: begin
          if (soak_done) phase_nxt = wse_pkg::PH_DELAY1;
        end
        wse_pkg::PH_SOAK2: begin
          if (soak_done) phase_nxt = wse_pkg::PH_DELAY2;
        end
        wse_pkg::PH_DELAY1: begin
          if (step_done) phase_nxt = wse_pkg::PH_HANDOFF1;
        end
        wse_pkg::PH_DELAY2: begin
          if (step_done) phase_nxt = wse_pkg::PH_HANDOFF2;
        end
        wse_pkg::PH_HANDOFF1: begin
          if (step_done) phase_nxt = wse_pkg::PH_DRAIN1;
        end
        wse_pkg::PH_HANDOFF2: begin
          if (step_done) phase_nxt = wse_pkg::PH_DRAIN2;
        end
        wse_pkg::PH_DRAIN1: begin
          if (!item.drain_busy) begin
            phase_nxt = wse_pkg::PH_REFILL_WAIT;
          end else if (drain_done) begin
            phase_nxt = wse_pkg::PH_IDLE;
          end
        end
        wse_pkg::PH_DRAIN2: begin
          if (!item.drain_busy) begin
            phase_nxt = wse_pkg::PH_POST;
          end else if (drain_done) begin
            phase_nxt = wse_pkg::PH_IDLE;
          end
        end
        wse_pkg::PH_REFILL_WAIT: begin
          if (step_done) phase_nxt = wse_pkg::PH_FILL2;
        end
        wse_pkg::PH_POST: begin
          if (step_done) phase_nxt = wse_pkg::PH_FINISH;
        end
        wse_pkg::PH_FINISH: begin
          if (step_done) phase_nxt = wse_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = wse_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    start_ms_nxt = start_ms_r;
    permit_nxt   = permit_r;
    act_nxt      = act_r;
    sample_nxt   = sample_r;
    drain_cmd    = wse_pkg::DRAIN_NONE;
    clr          = 1'b0;
    code         = wse_pkg::ABORT_NONE;
    if (!item.start_request) begin
      start_ms_nxt = '0;
      permit_nxt   = 1'b0;
      act_nxt      = '0;
      sample_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        wse_pkg::PH_IDLE: begin
        end
        wse_pkg::PH_ARM: begin
          act_nxt      = '0;
          permit_nxt   = 1'b0;
          sample_nxt   = 1'b1;
          start_ms_nxt = item.now_ms;
        end
        wse_pkg::PH_FILL1, wse_pkg::PH_FILL2: begin
          if (fill_abort) begin
            clr = 1'b1;
            if (low_to) begin
              code = is_fill2 ? wse_pkg::ABORT_LOW2 : wse_pkg::ABORT_LOW1;
            end else begin
              code = is_fill2 ? wse_pkg::ABORT_TOTAL2 : wse_pkg::ABORT_TOTAL1;
            end
            start_ms_nxt = '0;
            permit_nxt   = 1'b0;
            act_nxt      = '0;
            sample_nxt   = 1'b0;
          end else begin
            if (!is_fill2) begin
              act_nxt[wse_pkg::ACT_OUTLET] = 1'b0;
              act_nxt[wse_pkg::ACT_CIRC]   = 1'b0;
            end
            permit_nxt                  = fill_permit;
            act_nxt[wse_pkg::ACT_PUMP]  = fill_permit;
            act_nxt[wse_pkg::ACT_INLET] = !fill_done;
            if (fill_done) start_ms_nxt = item.now_ms;
          end
        end
        wse_pkg::PH_SOAK1, wse_pkg::PH_SOAK2: begin
          act_nxt[wse_pkg::ACT_PUMP] = permit_r;
          if (soak_done) begin
            permit_nxt                   = 1'b0;
            act_nxt[wse_pkg::ACT_PUMP]   = 1'b0;
            act_nxt[wse_pkg::ACT_OUTLET] = 1'b0;
            start_ms_nxt                 = item.now_ms;
          end
        end
        wse_pkg::PH_DELAY1, wse_pkg::PH_DELAY2: begin
          if (step_done) begin
            act_nxt[wse_pkg::ACT_CIRC] = 1'b1;
            start_ms_nxt               = item.now_ms;
          end
        end
        wse_pkg::PH_HANDOFF1, wse_pkg::PH_HANDOFF2: begin
          if (step_done) begin
            permit_nxt   = 1'b0;
            act_nxt      = '0;
            drain_cmd    = wse_pkg::DRAIN_SET;
            start_ms_nxt = item.now_ms;
          end
        end
        wse_pkg::PH_DRAIN1, wse_pkg::PH_DRAIN2: begin
          if (!item.drain_busy) begin
            start_ms_nxt = item.now_ms;
          end else if (drain_done) begin
            drain_cmd    = wse_pkg::DRAIN_CLEAR;
            clr          = 1'b1;
            code         = (phase_r == wse_pkg::PH_DRAIN1) ? wse_pkg::ABORT_DRAIN1
                                                          : wse_pkg::ABORT_DRAIN2;
            start_ms_nxt = '0;
            permit_nxt   = 1'b0;
            act_nxt      = '0;
            sample_nxt   = 1'b0;
          end
        end
        wse_pkg::PH_REFILL_WAIT: begin
          if (step_done) begin
            act_nxt[wse_pkg::ACT_INLET] = 1'b1;
            start_ms_nxt                = item.now_ms;
          end
        end
        wse_pkg::PH_POST: begin
        end
        wse_pkg::PH_FINISH: begin
          if (step_done) begin
            clr          = 1'b1;
            start_ms_nxt = '0;
            permit_nxt   = 1'b0;
            act_nxt      = '0;
            sample_nxt   = 1'b0;
          end
        end
        default: begin
          start_ms_nxt = '0;
          permit_nxt   = 1'b0;
          act_nxt      = '0;
          sample_nxt   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wse_pkg::PH_IDLE;
      start_ms_r <= '0;
      permit_r   <= 1'b0;
      act_r      <= '0;
      sample_r   <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      start_ms_r <= start_ms_nxt;
      permit_r   <= permit_nxt;
      act_r      <= act_nxt;
      sample_r   <= sample_nxt;
    end
  end

  always_comb begin
    result.inlet_valve   = act_nxt[wse_pkg::ACT_INLET];
    result.circ_pump     = act_nxt[wse_pkg::ACT_PUMP];
    result.circ_valve    = act_nxt[wse_pkg::ACT_CIRC];
    result.outlet_valve  = act_nxt[wse_pkg::ACT_OUTLET];
    result.sample_enable = sample_nxt;
    result.pump_permit   = permit_nxt;
    result.drain_command = drain_cmd;
    result.clear_start   = clr;
    result.abort_code    = code;
    result.phase         = phase_nxt;
  end

endmodule

// ===== rtl/core/wse_out_reg.sv =====
// ----------------------------------------------------------------------------
// wse_out_reg
// Result register; it can reload in the same cycle in which its word is taken.
// ----------------------------------------------------------------------------
module wse_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  wse_pkg::out_item_t load_data,
  input  logic               take,
  output logic               free,
  output logic               valid,
  output wse_pkg::out_item_t data
);

  logic               valid_r;
  logic               valid_nxt;
  wse_pkg::out_item_t data_r;

  assign free      = !valid_r || take;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule
